// File: hw/rtl/iea_pkg.sv
package iea_pkg;

    // Width of the sequence, pending and peak counters
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned OUT_W  = 32;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned N_KIND = 3;

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [OUT_W-1:0]  t_out;
    typedef logic [TIME_W-1:0] t_time;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_AL    = 2'd0,
        OP_SYNC0 = 2'd1,
        OP_SYNC1 = 2'd2,
        OP_SNAP  = 2'd3
    } t_op;

    // One result word
    typedef struct packed {
        logic  wake_request;
        logic  any_pending;
        t_out  pending_peak;
        t_out  al_pend;
        t_out  sync0_pend;
        t_out  sync1_pend;
        t_out  al_seq;
        t_out  sync0_seq;
        t_out  sync1_seq;
        t_time al_time;
        t_time sync0_time;
        t_time sync1_time;
    } t_result;

    // Low OUT_W bits of a counter, zero-extended if the counter is narrower
    function automatic t_out cnt_to_out(input t_cnt v);
        logic [CNT_W+OUT_W-1:0] ext;
        ext = {{OUT_W{1'b0}}, v};
        return ext[OUT_W-1:0];
    endfunction

endpackage

// File: hw/rtl/iea_in_if.sv
interface iea_in_if import iea_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  [1:0] op;
    t_time event_time;

    modport source (output valid, output op, output event_time, input ready);
    modport sink   (input valid, input op, input event_time, output ready);
endinterface

// File: hw/rtl/iea_out_if.sv
interface iea_out_if import iea_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  wake_request;
    logic  any_pending;
    t_out  pending_peak;
    t_out  al_pend;
    t_out  sync0_pend;
    t_out  sync1_pend;
    t_out  al_seq;
    t_out  sync0_seq;
    t_out  sync1_seq;
    t_time al_time;
    t_time sync0_time;
    t_time sync1_time;

    modport source (
        output valid, output wake_request, output any_pending, output pending_peak,
        output al_pend, output sync0_pend, output sync1_pend,
        output al_seq, output sync0_seq, output sync1_seq,
        output al_time, output sync0_time, output sync1_time,
        input ready
    );
    modport sink (
        input valid, input wake_request, input any_pending, input pending_peak,
        input al_pend, input sync0_pend, input sync1_pend,
        input al_seq, input sync0_seq, input sync1_seq,
        input al_time, input sync0_time, input sync1_time,
        output ready
    );
endinterface

// File: hw/rtl/interrupt_event_aggregator.sv
// Each accepted word's result is registered. Throughput: one word per cycle while the
// skid entry is free; the state update for a word is increments of count and sequence,
// a three-way counter sum and a peak compare, all done in the accept cycle. A two-entry
// output stage (result register plus skid) keeps input ready while one result waits.
// Reset (i_rst_n, synchronous, active low) zeroes all counters, sequence numbers,
// timestamps, the peak and the wake flag, and empties the output stage.
module interrupt_event_aggregator import iea_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iea_in_if.sink        i_evt,
    iea_out_if.source     o_res
);

    // ---------------------------------------------------------------
    // Aggregation state
    // ---------------------------------------------------------------
    t_cnt  r_gseq;
    t_cnt  r_cnt  [N_KIND];
    t_cnt  r_seq  [N_KIND];
    t_time r_time [N_KIND];
    t_cnt  r_peak;
    logic  r_wake_q;

    t_cnt  n_gseq;
    t_cnt  n_cnt  [N_KIND];
    t_cnt  n_seq  [N_KIND];
    t_time n_time [N_KIND];
    t_cnt  n_peak;
    logic  n_wake_q;

    // ---------------------------------------------------------------
    // Output stage: result register and skid entry
    // ---------------------------------------------------------------
    t_result r_out;
    logic    r_out_vld;
    t_result r_skid;
    logic    r_skid_vld;

    t_result new_res;
    t_cnt    ev_cnt [N_KIND];   // counts after the increment
    t_cnt    total;
    logic    accept;
    logic    take;
    logic    is_snap;
    logic    is_ev;
    logic    wake;
    logic    any;

    // Input is taken whenever the skid entry is free
    assign i_evt.ready = !r_skid_vld;
    assign accept      = i_evt.valid && !r_skid_vld;
    assign take        = r_out_vld && o_res.ready;
    assign is_snap     = (i_evt.op == OP_SNAP);
    assign is_ev       = accept && !is_snap;

    // ---------------------------------------------------------------
    // Next-state logic for one word
    // ---------------------------------------------------------------
    always_comb begin
        n_gseq   = r_gseq;
        n_peak   = r_peak;
        n_wake_q = r_wake_q;
        for (int k = 0; k < N_KIND; k++) begin
            ev_cnt[k] = r_cnt[k];
            n_cnt[k]  = r_cnt[k];
            n_seq[k]  = r_seq[k];
            n_time[k] = r_time[k];
        end

        // Sequence advances before it is stamped on the event kind
        if (is_ev) begin
            for (int k = 0; k < N_KIND; k++) begin
                if (i_evt.op == 2'(k)) begin
                    ev_cnt[k] = r_cnt[k] + CNT_W'(1);
                    n_seq[k]  = r_gseq + CNT_W'(1);
                    n_time[k] = i_evt.event_time;
                end
            end
        end

        // Counter sum wraps at the counter width
        total = ev_cnt[0] + ev_cnt[1] + ev_cnt[2];
        wake  = !is_snap && !r_wake_q;
        any   = (r_cnt[0] != '0) || (r_cnt[1] != '0) || (r_cnt[2] != '0);

        if (accept) begin
            if (is_snap) begin
                // Snapshot: report, then clear counts and the wake flag
                for (int k = 0; k < N_KIND; k++) begin
                    n_cnt[k] = '0;
                end
                n_wake_q = 1'b0;
            end else begin
                n_gseq = r_gseq + CNT_W'(1);
                for (int k = 0; k < N_KIND; k++) begin
                    n_cnt[k] = ev_cnt[k];
                end
                if (total > r_peak) begin
                    n_peak = total;
                end
                n_wake_q = 1'b1;
            end
        end
    end

    // Result word: event reports post-update values, snapshot pre-clear counts
    always_comb begin
        new_res              = '0;
        new_res.wake_request = wake;
        new_res.any_pending  = is_snap && any;
        new_res.pending_peak = cnt_to_out((!is_snap && total > r_peak) ? total : r_peak);
        new_res.al_pend      = cnt_to_out(ev_cnt[0]);
        new_res.sync0_pend   = cnt_to_out(ev_cnt[1]);
        new_res.sync1_pend   = cnt_to_out(ev_cnt[2]);
        new_res.al_seq       = cnt_to_out(n_seq[0]);
        new_res.sync0_seq    = cnt_to_out(n_seq[1]);
        new_res.sync1_seq    = cnt_to_out(n_seq[2]);
        new_res.al_time      = n_time[0];
        new_res.sync0_time   = n_time[1];
        new_res.sync1_time   = n_time[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gseq   <= '0;
            r_peak   <= '0;
            r_wake_q <= 1'b0;
            for (int k = 0; k < N_KIND; k++) begin
                r_cnt[k]  <= '0;
                r_seq[k]  <= '0;
                r_time[k] <= '0;
            end
        end else begin
            r_gseq   <= n_gseq;
            r_peak   <= n_peak;
            r_wake_q <= n_wake_q;
            for (int k = 0; k < N_KIND; k++) begin
                r_cnt[k]  <= n_cnt[k];
                r_seq[k]  <= n_seq[k];
                r_time[k] <= n_time[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Output stage control
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (take) begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld  <= accept;
                end
            end else if (accept) begin
                if (r_out_vld) begin
                    r_skid_vld <= 1'b1;
                end else begin
                    r_out_vld  <= 1'b1;
                end
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (take && r_skid_vld) begin
            r_out <= r_skid;
        end else if (accept && (take || !r_out_vld)) begin
            r_out <= new_res;
        end
        if (accept && r_out_vld && !take) begin
            r_skid <= new_res;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.wake_request = r_out.wake_request;
    assign o_res.any_pending  = r_out.any_pending;
    assign o_res.pending_peak = r_out.pending_peak;
    assign o_res.al_pend      = r_out.al_pend;
    assign o_res.sync0_pend   = r_out.sync0_pend;
    assign o_res.sync1_pend   = r_out.sync1_pend;
    assign o_res.al_seq       = r_out.al_seq;
    assign o_res.sync0_seq    = r_out.sync0_seq;
    assign o_res.sync1_seq    = r_out.sync1_seq;
    assign o_res.al_time      = r_out.al_time;
    assign o_res.sync0_time   = r_out.sync0_time;
    assign o_res.sync1_time   = r_out.sync1_time;

`ifndef NO_ASSERTIONS
    // Skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry valid with empty result register");

    // A word is either an event or a snapshot, never both flags
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.wake_request && r_out.any_pending))
        else $error("wake and any_pending both set");

    // Every event leaves the wake flag set and advances the sequence by one
    a_event_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_ev |=> (r_wake_q && r_gseq == $past(r_gseq) + CNT_W'(1)))
        else $error("event did not set wake or advance sequence");

    // Snapshot clears every count and the wake flag
    a_snap_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_snap) |=>
            (!r_wake_q && r_cnt[0] == '0 && r_cnt[1] == '0 && r_cnt[2] == '0))
        else $error("snapshot did not clear state");
`endif

endmodule

// File: tb/sv/iea_result_checker.sv
// Watches both channels of the event aggregator, keeps its own copy of the
// aggregator state and compares every result word against it.
module iea_result_checker import iea_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    iea_in_if    i_evt,
    iea_out_if   i_res,
    output int   o_outstanding,
    output int   o_mismatches,
    output int   o_checked
);

    localparam int REPORT_LIMIT = 10;

    // mirrored aggregator state
    t_cnt  seq_no;
    t_cnt  kind_count [N_KIND];
    t_cnt  kind_seq   [N_KIND];
    t_time kind_time  [N_KIND];
    t_cnt  peak_total;
    logic  wake_flag;

    t_result awaited_words [$];
    int      n_bad;
    int      n_checked;

    assign o_mismatches = n_bad;
    assign o_checked    = n_checked;

    function automatic t_result state_word(input logic wake, input logic any);
        t_result r;
        r.wake_request = wake;
        r.any_pending  = any;
        r.pending_peak = peak_total;
        r.al_pend      = kind_count[OP_AL];
        r.sync0_pend   = kind_count[OP_SYNC0];
        r.sync1_pend   = kind_count[OP_SYNC1];
        r.al_seq       = kind_seq[OP_AL];
        r.sync0_seq    = kind_seq[OP_SYNC0];
        r.sync1_seq    = kind_seq[OP_SYNC1];
        r.al_time      = kind_time[OP_AL];
        r.sync0_time   = kind_time[OP_SYNC0];
        r.sync1_time   = kind_time[OP_SYNC1];
        return r;
    endfunction

    // Advance the mirrored state by one input word, return the word it yields
    function automatic t_result aggregate_word(input t_op op, input t_time ts);
        t_result r;
        t_cnt    total;
        logic    woke;
        if (op == OP_SNAP) begin
            r = state_word(1'b0, (kind_count[OP_AL] | kind_count[OP_SYNC0] |
                                  kind_count[OP_SYNC1]) != '0);
            foreach (kind_count[k]) kind_count[k] = '0;
            wake_flag = 1'b0;
        end else begin
            seq_no         = seq_no + 1'b1;
            kind_count[op] = kind_count[op] + 1'b1;
            kind_seq[op]   = seq_no;
            kind_time[op]  = ts;
            total = kind_count[OP_AL] + kind_count[OP_SYNC0] + kind_count[OP_SYNC1];
            if (total > peak_total) peak_total = total;
            woke      = !wake_flag;
            wake_flag = 1'b1;
            r = state_word(woke, 1'b0);
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            n_bad++;
            if (n_bad <= REPORT_LIMIT)
                $display("mismatch on result word %0d, %s: expected %h, got %h",
                         n_checked, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            seq_no     = '0;
            peak_total = '0;
            wake_flag  = 1'b0;
            foreach (kind_count[k]) begin
                kind_count[k] = '0;
                kind_seq[k]   = '0;
                kind_time[k]  = '0;
            end
            awaited_words.delete();
            o_outstanding <= 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.wake_request = i_res.wake_request;
                got.any_pending  = i_res.any_pending;
                got.pending_peak = i_res.pending_peak;
                got.al_pend      = i_res.al_pend;
                got.sync0_pend   = i_res.sync0_pend;
                got.sync1_pend   = i_res.sync1_pend;
                got.al_seq       = i_res.al_seq;
                got.sync0_seq    = i_res.sync0_seq;
                got.sync1_seq    = i_res.sync1_seq;
                got.al_time      = i_res.al_time;
                got.sync0_time   = i_res.sync0_time;
                got.sync1_time   = i_res.sync1_time;
                if (awaited_words.size() == 0) begin
                    n_bad++;
                    if (n_bad <= REPORT_LIMIT)
                        $display("result word %0d arrived with none outstanding", n_checked);
                end else begin
                    want = awaited_words.pop_front();
                    check_field("wake_request", 32'(want.wake_request), 32'(got.wake_request));
                    check_field("any_pending",  32'(want.any_pending),  32'(got.any_pending));
                    check_field("pending_peak", want.pending_peak, got.pending_peak);
                    check_field("al_pend",      want.al_pend,      got.al_pend);
                    check_field("sync0_pend",   want.sync0_pend,   got.sync0_pend);
                    check_field("sync1_pend",   want.sync1_pend,   got.sync1_pend);
                    check_field("al_seq",       want.al_seq,       got.al_seq);
                    check_field("sync0_seq",    want.sync0_seq,    got.sync0_seq);
                    check_field("sync1_seq",    want.sync1_seq,    got.sync1_seq);
                    check_field("al_time",      want.al_time,      got.al_time);
                    check_field("sync0_time",   want.sync0_time,   got.sync0_time);
                    check_field("sync1_time",   want.sync1_time,   got.sync1_time);
                end
                n_checked++;
            end
            if (i_evt.valid && i_evt.ready)
                awaited_words.push_back(aggregate_word(t_op'(i_evt.op), i_evt.event_time));
            o_outstanding <= awaited_words.size();
        end
    end

endmodule

// File: tb/sv/interrupt_event_aggregator_test.sv
// Top of the aggregator bench: clock, reset, word traffic on both channels
// and the verdict. Prediction and comparison live in the checker.
module interrupt_event_aggregator_test import iea_pkg::*; ();

    localparam int RANDOM_WORDS = 900;
    localparam int HOLD_CYCLES  = 120;     // long receiver hold-off
    localparam int CYCLE_LIMIT  = 200000;  // far above any sane run

    typedef enum logic [1:0] {
        RX_FREE,     // always ready
        RX_COIN,     // ready on a coin toss
        RX_PATTERN,  // ready follows a rotating bit pattern
        RX_SPARSE    // mostly stalled
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    iea_in_if  evt_if ();
    iea_out_if res_if ();

    int mismatches;
    int outstanding;
    int words_checked;

    int cycle_no = 0;
    int burst_left;
    int n_sent;
    int n_events;
    int n_snaps;

    interrupt_event_aggregator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_if),
        .o_res   (res_if)
    );

    iea_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_evt         (evt_if),
        .i_res         (res_if),
        .o_outstanding (outstanding),
        .o_mismatches  (mismatches),
        .o_checked     (words_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still outstanding",
                     cycle_no, outstanding);
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one word and hold it until taken. Words go out in bursts; when a
    // burst is used up, valid drops for a random gap before the next one.
    task automatic send_word(input t_op op, input t_time ts);
        if (burst_left == 0) begin
            evt_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            // one burst in eight is long, giving stretches with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 12);
        end
        evt_if.valid      <= 1'b1;
        evt_if.op         <= op;
        evt_if.event_time <= ts;
        do @(posedge i_clk); while (!evt_if.ready);
        burst_left--;
        n_sent++;
        if (op == OP_SNAP) n_snaps++;
        else               n_events++;
    endtask

    // Stop offering and let the block drain completely
    task automatic wait_drained();
        evt_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Receiver: random stall modes in segments, plus two long hold-offs that
    // fill the output stage and push back on the input while words keep coming
    initial begin : receiver
        t_rx_mode   mode;
        int         seg_len;
        int         rx_cycles;
        logic [7:0] stall_pattern;
        res_if.ready <= 1'b0;
        rx_cycles = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            mode          = t_rx_mode'($urandom_range(0, 3));
            seg_len       = $urandom_range(16, 160);
            stall_pattern = 8'($urandom());
            repeat (seg_len) begin
                if (rx_cycles == 400 || rx_cycles == 1500) begin
                    res_if.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    rx_cycles += HOLD_CYCLES;
                end
                case (mode)
                    RX_FREE:    res_if.ready <= 1'b1;
                    RX_COIN:    res_if.ready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: res_if.ready <= stall_pattern[0];
                    default:    res_if.ready <= ($urandom_range(0, 4) == 0);
                endcase
                stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
                @(posedge i_clk);
                rx_cycles++;
            end
        end
    end

    // Sender: reset, directed words, then random event runs closed by snapshots
    initial begin : sender
        int    run_len;
        int    fill_to;
        logic  one_kind;
        t_op   kind;
        t_time ts;
        logic  paused;

        i_rst_n    <= 1'b0;
        evt_if.valid      <= 1'b0;
        evt_if.op         <= OP_AL;
        evt_if.event_time <= '0;
        burst_left = 0;
        n_sent     = 0;
        n_events   = 0;
        n_snaps    = 0;
        paused     = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // snapshot straight out of reset: everything zero, nothing pending
        send_word(OP_SNAP,  32'hFFFF_FFFF);
        // first event raises wake, the second of the same kind does not
        send_word(OP_AL,    32'h0000_0000);
        send_word(OP_AL,    32'hFFFF_FFFF);
        send_word(OP_SYNC0, 32'h8000_0000);
        send_word(OP_SYNC1, 32'h0000_0001);
        send_word(OP_SYNC1, 32'h7FFF_FFFF);
        // snapshot with pending counts, then one with nothing left
        send_word(OP_SNAP,  32'h1234_5678);
        send_word(OP_SNAP,  32'h0000_0000);
        // wake comes back after a clear; peak stays above the new total
        send_word(OP_SYNC0, 32'hA5A5_A5A5);
        send_word(OP_SNAP,  32'h5A5A_5A5A);
        send_word(OP_SYNC1, 32'h5A5A_5A5A);
        for (int i = 0; i < 7; i++)
            send_word(OP_AL, 32'h0000_0001 << (i * 5));
        send_word(OP_SYNC0, 32'hFFFF_FFFE);
        // total of nine beats the earlier peak of five
        send_word(OP_SNAP,  32'hDEAD_BEEF);

        // first pause: let every outstanding word arrive before going random
        wait_drained();

        fill_to = n_sent + RANDOM_WORDS;
        while (n_sent < fill_to) begin
            // mostly short runs; now and then a long one to push the peak up
            run_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(0, 10);
            one_kind = ($urandom_range(0, 3) == 0);
            kind     = t_op'($urandom_range(0, 2));
            for (int i = 0; i < run_len; i++) begin
                ts = ($urandom_range(0, 15) == 0) ? '1 : t_time'($urandom());
                send_word(one_kind ? kind : t_op'($urandom_range(0, 2)), ts);
            end
            send_word(OP_SNAP, t_time'($urandom()));
            if (!paused && n_sent >= fill_to - RANDOM_WORDS / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("drove %0d event words and %0d snapshots in bursts under receiver stalls,",
                 n_events, n_snaps);
        $display("checked %0d result words field by field", words_checked);
        if (mismatches == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d field mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/iea_pkg.sv
hw/rtl/iea_in_if.sv
hw/rtl/iea_out_if.sv
hw/rtl/interrupt_event_aggregator.sv
tb/sv/iea_result_checker.sv
tb/sv/interrupt_event_aggregator_test.sv
